// ----- hw/rtl/fct_pkg.sv -----
// Shared types, widths and helpers for the frustum cull tester.
// Depends on nothing; every other file of the block uses it by scoped names.
package fct_pkg;

  // Fixed point format of all coordinates and matrix elements
  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int FIELD_W     = 32;

  localparam int MAT_DIM    = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;

  // Plane coefficient: sum of two elements, one bit of growth plus sign room
  localparam int COEF_W = COORD_WIDTH + 2;
  // Magnitude of a coefficient never exceeds 2^COORD_WIDTH
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * COORD_WIDTH + 2;
  localparam int P3_W   = COEF_W + FRAC_BITS;
  localparam int RAD_W  = COORD_WIDTH + FRAC_BITS;
  // Seven terms at most are summed: three bits of growth over the widest
  localparam int SUM_W  = ((PROD_W > P3_W) ? PROD_W : P3_W) + 3;

  typedef logic signed [COORD_WIDTH-1:0] val_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic        [MAG_W-1:0]       mag_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [P3_W-1:0]        p3_t;
  typedef logic signed [RAD_W-1:0]       rad_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_SETUP  = 3'd1,
    MODE_POINT  = 3'd2,
    MODE_SPHERE = 3'd3,
    MODE_BOX    = 3'd4,
    MODE_INVAL  = 3'd5
  } mode_t;

  // State update request from the input side to the plane store
  typedef struct packed {
    logic       load;
    logic       setup;
    logic       inval;
    logic [1:0] row;
    logic [1:0] col;
    val_t       value;
  } store_req_t;

  // Slack selection for one cull in the summing stage
  typedef struct packed {
    logic sphere;
    logic box;
  } slack_ctrl_t;

  // Take the low COORD_WIDTH bits of a field as a signed value
  function automatic val_t field_val(logic [FIELD_W-1:0] v);
    return v[COORD_WIDTH-1:0];
  endfunction

  // Magnitude of a plane coefficient
  function automatic mag_t coef_mag(coef_t c);
    coef_t n;
    n = -c;
    return c[COEF_W-1] ? n[MAG_W-1:0] : c[MAG_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/fct_plane_store.sv -----
// Matrix element registers, plane derivation on setup, plane registers and
// the planes-valid flag. Depends on fct_pkg.
module fct_plane_store (
  input  logic                 clk,
  input  logic                 rst,
  input  fct_pkg::store_req_t  req,
  output fct_pkg::coef_t       plane [fct_pkg::NUM_PLANES][fct_pkg::MAT_DIM],
  output fct_pkg::mag_t        plane_mag [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES],
  output logic                 planes_valid
);

  fct_pkg::val_t  matrix [fct_pkg::MAT_DIM][fct_pkg::MAT_DIM];
  fct_pkg::coef_t plane_next [fct_pkg::NUM_PLANES][fct_pkg::MAT_DIM];
  fct_pkg::mag_t  plane_mag_next [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES];

  // Derive near/far style plane pairs: minus and plus axis column, less column 3
  always_comb begin
    fct_pkg::coef_t ma;
    fct_pkg::coef_t mw;
    for (int a = 0; a < fct_pkg::NUM_AXES; a++) begin
      for (int i = 0; i < fct_pkg::MAT_DIM; i++) begin
        ma = fct_pkg::coef_t'(matrix[i][a]);
        mw = fct_pkg::coef_t'(matrix[i][fct_pkg::MAT_DIM-1]);
        plane_next[2*a][i]   = -ma - mw;
        plane_next[2*a+1][i] = ma - mw;
      end
    end
    for (int p = 0; p < fct_pkg::NUM_PLANES; p++) begin
      for (int i = 0; i < fct_pkg::NUM_AXES; i++) begin
        plane_mag_next[p][i] = fct_pkg::coef_mag(plane_next[p][i]);
      end
    end
  end

  // Write elements, latch planes on setup, track the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      planes_valid <= 1'b0;
      for (int r = 0; r < fct_pkg::MAT_DIM; r++) begin
        for (int c = 0; c < fct_pkg::MAT_DIM; c++) begin
          matrix[r][c] <= '0;
        end
      end
      for (int p = 0; p < fct_pkg::NUM_PLANES; p++) begin
        for (int i = 0; i < fct_pkg::MAT_DIM; i++) begin
          plane[p][i] <= '0;
        end
        for (int i = 0; i < fct_pkg::NUM_AXES; i++) begin
          plane_mag[p][i] <= '0;
        end
      end
    end else begin
      if (req.load) begin
        matrix[req.row][req.col] <= req.value;
      end
      if (req.setup) begin
        planes_valid <= 1'b1;
        plane        <= plane_next;
        plane_mag    <= plane_mag_next;
      end else if (req.inval) begin
        planes_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/fct_plane_eval.sv -----
// One frustum plane test: registered products, then exact sum and sign check.
// Depends on fct_pkg.
module fct_plane_eval (
  input  logic                 clk,
  input  logic                 en,
  input  fct_pkg::val_t        coord [fct_pkg::NUM_AXES],
  input  fct_pkg::val_t        half [fct_pkg::NUM_AXES],
  input  fct_pkg::coef_t       coef [fct_pkg::MAT_DIM],
  input  fct_pkg::mag_t        coef_mag [fct_pkg::NUM_AXES],
  input  fct_pkg::slack_ctrl_t ctrl,
  input  fct_pkg::rad_t        rad_term,
  output logic                 outside
);

  fct_pkg::prod_t cprod [fct_pkg::NUM_AXES];
  fct_pkg::prod_t hprod [fct_pkg::NUM_AXES];
  fct_pkg::p3_t   p3_term;
  fct_pkg::sum_t  plane_dist;

  // Multiply centre by coefficient and extent by coefficient magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < fct_pkg::NUM_AXES; i++) begin
        cprod[i] <= fct_pkg::prod_t'(coord[i]) * fct_pkg::prod_t'(coef[i]);
        hprod[i] <= fct_pkg::prod_t'(half[i]) *
                    fct_pkg::prod_t'($signed({1'b0, coef_mag[i]}));
      end
      p3_term <= $signed({coef[fct_pkg::MAT_DIM-1], {fct_pkg::FRAC_BITS{1'b0}}});
    end
  end

  // Sum the plane distance less the slack of the volume
  always_comb begin
    fct_pkg::sum_t slack;
    slack = '0;
    if (ctrl.sphere) begin
      slack = fct_pkg::sum_t'(rad_term);
    end else if (ctrl.box) begin
      slack = fct_pkg::sum_t'(hprod[0]) + fct_pkg::sum_t'(hprod[1]) +
              fct_pkg::sum_t'(hprod[2]);
    end
    plane_dist = fct_pkg::sum_t'(cprod[0]) + fct_pkg::sum_t'(cprod[1]) +
                 fct_pkg::sum_t'(cprod[2]) + fct_pkg::sum_t'(p3_term) - slack;
  end

  assign outside = !plane_dist[fct_pkg::SUM_W-1] && (plane_dist != '0);

endmodule

// ----- hw/rtl/frustum_cull_tester.sv -----
// Frustum cull tester: load a view-projection matrix element by element, set up
// six planes from it, then stream point, sphere and box requests for culling.
// Throughput is one request per cycle with no bubbles while the result side
// does not stall; every request gives exactly one result, registered through
// the input register loaded at acceptance, the product register and the result
// register, with the six plane units working in parallel, each with its
// multipliers between the input and product registers. Load, setup and
// invalidate act on the plane state at acceptance, so a cull accepted in the
// following cycle already sees them. Reset needs no clearing pass.
// Depends on fct_pkg, fct_plane_store and fct_plane_eval.
module frustum_cull_tester (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [1:0]  elem_row,
  input  logic [1:0]  elem_col,
  input  logic [31:0] elem_value,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [31:0] sphere_radius,
  input  logic [31:0] half_x,
  input  logic [31:0] half_y,
  input  logic [31:0] half_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        culled,
  output logic        status
);

  logic                 adv;
  logic                 accept;
  logic                 is_cull;
  logic                 is_sphere;
  logic                 is_box;
  fct_pkg::store_req_t  req;
  fct_pkg::coef_t       plane [fct_pkg::NUM_PLANES][fct_pkg::MAT_DIM];
  fct_pkg::mag_t        plane_mag [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES];
  logic                 planes_valid;

  // Input register
  logic                 s1_valid;
  logic                 s1_cull;
  logic                 s1_ready;
  fct_pkg::slack_ctrl_t s1_ctrl;
  fct_pkg::val_t        s1_coord [fct_pkg::NUM_AXES];
  fct_pkg::val_t        s1_half [fct_pkg::NUM_AXES];
  fct_pkg::val_t        s1_rad;

  // Product register
  logic                 s2_valid;
  logic                 s2_cull;
  logic                 s2_ready;
  fct_pkg::slack_ctrl_t s2_ctrl;
  fct_pkg::rad_t        s2_rad_term;
  logic [fct_pkg::NUM_PLANES-1:0] outside;

  // Whole pipeline moves together unless the result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = rst || !adv;
  assign accept   = in_valid && !in_stall;

  // Decode the request mode
  always_comb begin
    is_cull   = 1'b0;
    is_sphere = 1'b0;
    is_box    = 1'b0;
    req.load  = 1'b0;
    req.setup = 1'b0;
    req.inval = 1'b0;
    unique case (mode)
      fct_pkg::MODE_LOAD:   req.load  = accept;
      fct_pkg::MODE_SETUP:  req.setup = accept;
      fct_pkg::MODE_INVAL:  req.inval = accept;
      fct_pkg::MODE_POINT:  is_cull   = 1'b1;
      fct_pkg::MODE_SPHERE: begin
        is_cull   = 1'b1;
        is_sphere = 1'b1;
      end
      fct_pkg::MODE_BOX: begin
        is_cull = 1'b1;
        is_box  = 1'b1;
      end
      default: is_cull = 1'b0;
    endcase
    req.row   = elem_row;
    req.col   = elem_col;
    req.value = fct_pkg::field_val(elem_value);
  end

  fct_plane_store u_store (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .plane        (plane),
    .plane_mag    (plane_mag),
    .planes_valid (planes_valid)
  );

  // Capture the request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cull        <= is_cull;
      s1_ready       <= planes_valid;
      s1_ctrl.sphere <= is_sphere;
      s1_ctrl.box    <= is_box;
      s1_coord[0]    <= fct_pkg::field_val(coord_x);
      s1_coord[1]    <= fct_pkg::field_val(coord_y);
      s1_coord[2]    <= fct_pkg::field_val(coord_z);
      s1_half[0]     <= fct_pkg::field_val(half_x);
      s1_half[1]     <= fct_pkg::field_val(half_y);
      s1_half[2]     <= fct_pkg::field_val(half_z);
      s1_rad         <= fct_pkg::field_val(sphere_radius);
    end
  end

  // Advance control and the scaled radius alongside the products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cull     <= s1_cull;
      s2_ready    <= s1_ready;
      s2_ctrl     <= s1_ctrl;
      s2_rad_term <= $signed({s1_rad, {fct_pkg::FRAC_BITS{1'b0}}});
    end
  end

  // Six plane tests in parallel
  for (genvar p = 0; p < fct_pkg::NUM_PLANES; p++) begin : g_plane
    fct_plane_eval u_eval (
      .clk      (clk),
      .en       (adv),
      .coord    (s1_coord),
      .half     (s1_half),
      .coef     (plane[p]),
      .coef_mag (plane_mag[p]),
      .ctrl     (s2_ctrl),
      .rad_term (s2_rad_term),
      .outside  (outside[p])
    );
  end

  // Result register: culled only when planes are set up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      culled <= s2_cull && s2_ready && (|outside);
      status <= s2_cull && !s2_ready;
    end
  end

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(culled && status))
    else $error("culled and not-ready status both set");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !in_stall) |=> out_valid)
    else $error("request lost between product and result register");

  a_setup: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == fct_pkg::MODE_SETUP) |=> planes_valid)
    else $error("setup did not mark planes valid");

  a_inval: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == fct_pkg::MODE_INVAL) |=> !planes_valid)
    else $error("invalidate did not clear planes valid");
`endif

endmodule

// ----- tb/tb_frustum_cull_tester.sv -----
// Self-checking testbench for frustum_cull_tester: directed and random requests
// with a cycle-free scoreboard that predicts every culled/status result.
// Depends on fct_pkg for the mode codes and fixed point widths.

typedef logic signed [127:0] plane_sum_t;

typedef struct {
  logic [2:0]  mode;
  logic [1:0]  row;
  logic [1:0]  col;
  logic [31:0] value;
  logic [31:0] cx;
  logic [31:0] cy;
  logic [31:0] cz;
  logic [31:0] rad;
  logic [31:0] hx;
  logic [31:0] hy;
  logic [31:0] hz;
} cull_req_t;

typedef struct packed {
  logic culled;
  logic status;
} verdict_t;

// Plane state mirror plus the queue of verdicts still owed by the block
class cull_scoreboard;
  longint      matrix_q[16];
  longint      plane_q[fct_pkg::NUM_PLANES][fct_pkg::MAT_DIM];
  longint      plane_mag_q[fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES];
  bit          planes_set;
  verdict_t    expected_verdicts[$];
  int unsigned verdict_errors;

  // Sign-extend the low COORD_WIDTH bits of a field
  function longint to_fixed(logic [31:0] v);
    longint r;
    r = longint'(64'(v) & ((64'd1 << fct_pkg::COORD_WIDTH) - 64'd1));
    if (v[fct_pkg::COORD_WIDTH-1]) r = r - (longint'(1) << fct_pkg::COORD_WIDTH);
    return r;
  endfunction

  // Exact product, widened before multiplying
  function plane_sum_t mul_wide(longint a, longint b);
    plane_sum_t wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Update the mirrored state with one accepted request and queue its verdict
  function void apply_request(cull_req_t r);
    verdict_t   v;
    plane_sum_t plane_dist;
    longint     unit_q, cx, cy, cz, rad, hx, hy, hz, ma, mw;
    int         a, i, p;
    v = '0;
    unit_q = longint'(1) << fct_pkg::FRAC_BITS;
    case (r.mode) inside
      fct_pkg::MODE_LOAD: matrix_q[{r.row, r.col}] = to_fixed(r.value);
      fct_pkg::MODE_SETUP: begin
        for (a = 0; a < fct_pkg::NUM_AXES; a++) begin
          for (i = 0; i < fct_pkg::MAT_DIM; i++) begin
            ma = matrix_q[i*4 + a];
            mw = matrix_q[i*4 + 3];
            plane_q[2*a][i]   = -ma - mw;
            plane_q[2*a+1][i] = ma - mw;
          end
        end
        for (p = 0; p < fct_pkg::NUM_PLANES; p++) begin
          for (a = 0; a < fct_pkg::NUM_AXES; a++) begin
            plane_mag_q[p][a] = (plane_q[p][a] < 0) ? -plane_q[p][a] : plane_q[p][a];
          end
        end
        planes_set = 1'b1;
      end
      fct_pkg::MODE_INVAL: planes_set = 1'b0;
      fct_pkg::MODE_POINT, fct_pkg::MODE_SPHERE, fct_pkg::MODE_BOX: begin
        if (!planes_set) begin
          v.status = 1'b1;
        end else begin
          cx  = to_fixed(r.cx);
          cy  = to_fixed(r.cy);
          cz  = to_fixed(r.cz);
          rad = to_fixed(r.rad);
          hx  = to_fixed(r.hx);
          hy  = to_fixed(r.hy);
          hz  = to_fixed(r.hz);
          for (p = 0; p < fct_pkg::NUM_PLANES; p++) begin
            plane_dist = mul_wide(cx, plane_q[p][0]) + mul_wide(cy, plane_q[p][1])
                       + mul_wide(cz, plane_q[p][2]) + mul_wide(plane_q[p][3], unit_q);
            if (r.mode == fct_pkg::MODE_SPHERE) begin
              plane_dist = plane_dist - mul_wide(rad, unit_q);
            end else if (r.mode == fct_pkg::MODE_BOX) begin
              plane_dist = plane_dist - mul_wide(hx, plane_mag_q[p][0])
                         - mul_wide(hy, plane_mag_q[p][1])
                         - mul_wide(hz, plane_mag_q[p][2]);
            end
            if (plane_dist > 0) v.culled = 1'b1;
          end
        end
      end
      default: ;
    endcase
    expected_verdicts = {expected_verdicts, v};
  endfunction

  // Compare one result against the oldest queued verdict
  function void check_verdict(logic got_culled, logic got_status);
    verdict_t v;
    if (expected_verdicts.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual culled %0b status %0b",
               $time, got_culled, got_status);
      verdict_errors++;
      return;
    end
    v = expected_verdicts.pop_front();
    if (got_culled !== v.culled) begin
      $display("%0t: culled mismatch, expected %0b, actual %0b", $time, v.culled, got_culled);
      verdict_errors++;
    end
    if (got_status !== v.status) begin
      $display("%0t: status mismatch, expected %0b, actual %0b", $time, v.status, got_status);
      verdict_errors++;
    end
  endfunction
endclass

module tb_frustum_cull_tester;
  localparam logic [2:0]  MODE_SPARE_A   = 3'd6;
  localparam logic [2:0]  MODE_SPARE_B   = 3'd7;
  localparam int unsigned RANDOM_ITEMS   = 550;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MATRIX_SPAN    = 4 << 16;
  localparam int unsigned COORD_SPAN     = 3 << 16;
  localparam int unsigned EXTENT_SPAN    = 2 << 16;
  localparam logic [31:0] ONE_Q          = 32'h0001_0000;
  localparam logic [31:0] TWO_Q          = 32'h0002_0000;
  localparam logic [31:0] NEG_HALF_Q     = 32'hffff_8000;
  localparam logic [31:0] MIN_Q          = 32'h8000_0000;
  localparam logic [31:0] MAX_Q          = 32'h7fff_ffff;

  logic        clk;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        out_stall     = 1'b0;
  logic [2:0]  mode          = '0;
  logic [1:0]  elem_row      = '0;
  logic [1:0]  elem_col      = '0;
  logic [31:0] elem_value    = '0;
  logic [31:0] coord_x       = '0;
  logic [31:0] coord_y       = '0;
  logic [31:0] coord_z       = '0;
  logic [31:0] sphere_radius = '0;
  logic [31:0] half_x        = '0;
  logic [31:0] half_y        = '0;
  logic [31:0] half_z        = '0;
  logic        in_stall;
  logic        out_valid;
  logic        culled;
  logic        status;

  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    quiet_cycles   = 0;
  cull_scoreboard sb             = new();

  frustum_cull_tester u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .elem_row      (elem_row),
    .elem_col      (elem_col),
    .elem_value    (elem_value),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .sphere_radius (sphere_radius),
    .half_x        (half_x),
    .half_y        (half_y),
    .half_z        (half_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .culled        (culled),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Record accepted requests, check results, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.apply_request('{mode, elem_row, elem_col, elem_value, coord_x, coord_y,
                           coord_z, sphere_radius, half_x, half_y, half_z});
      end
      if (out_valid && !out_stall) sb.check_verdict(culled, status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("frustum_cull_tester regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Mostly small Q16.16 values, sometimes any pattern or an extreme
  function automatic logic [31:0] pick_q(int unsigned span);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) return $urandom_range(0, 2*span) - span;
    if (sel < 88) return $urandom;
    case ($urandom_range(4))
      0:       return MIN_Q;
      1:       return MAX_Q;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return ONE_Q;
    endcase
  endfunction

  // Radius or half extent: usually non-negative and small
  function automatic logic [31:0] pick_extent(int unsigned span);
    if ($urandom_range(99) < 80) return $urandom_range(0, span);
    return pick_q(span);
  endfunction

  // Fill every field with noise; callers overwrite the ones that matter
  function automatic cull_req_t noise_req(logic [2:0] m);
    cull_req_t r;
    r.mode  = m;
    r.row   = 2'($urandom);
    r.col   = 2'($urandom);
    r.value = $urandom;
    r.cx    = $urandom;
    r.cy    = $urandom;
    r.cz    = $urandom;
    r.rad   = $urandom;
    r.hx    = $urandom;
    r.hy    = $urandom;
    r.hz    = $urandom;
    return r;
  endfunction

  // Present one request after optional idle cycles and hold it until accepted
  task automatic send_request(cull_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode          = r.mode;
    elem_row      = r.row;
    elem_col      = r.col;
    elem_value    = r.value;
    coord_x       = r.cx;
    coord_y       = r.cy;
    coord_z       = r.cz;
    sphere_radius = r.rad;
    half_x        = r.hx;
    half_y        = r.hy;
    half_z        = r.hz;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic load_elem(int unsigned row, int unsigned col, logic [31:0] value);
    cull_req_t r;
    r       = noise_req(fct_pkg::MODE_LOAD);
    r.row   = 2'(row);
    r.col   = 2'(col);
    r.value = value;
    send_request(r);
  endtask

  task automatic issue(logic [2:0] m);
    send_request(noise_req(m));
  endtask

  task automatic cull(logic [2:0] m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [31:0] rad, logic [31:0] hx, logic [31:0] hy,
                      logic [31:0] hz);
    cull_req_t r;
    r     = noise_req(m);
    r.cx  = x;
    r.cy  = y;
    r.cz  = z;
    r.rad = rad;
    r.hx  = hx;
    r.hy  = hy;
    r.hz  = hz;
    send_request(r);
  endtask

  task automatic cull_random();
    logic [2:0] m;
    case ($urandom_range(2))
      0:       m = fct_pkg::MODE_POINT;
      1:       m = fct_pkg::MODE_SPHERE;
      default: m = fct_pkg::MODE_BOX;
    endcase
    cull(m, pick_q(COORD_SPAN), pick_q(COORD_SPAN), pick_q(COORD_SPAN),
         pick_extent(EXTENT_SPAN), pick_extent(EXTENT_SPAN), pick_extent(EXTENT_SPAN),
         pick_extent(EXTENT_SPAN));
  endtask

  // Hold off the sender until every verdict is in, then switch idle rates
  task automatic enter_phase(int unsigned send_pct, int unsigned recv_pct);
    in_valid = 1'b0;
    while (sb.expected_verdicts.size() != 0) @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int unsigned items, phase, style, e, n, k, sel;
    bit          partial;
    logic [31:0] value;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    enter_phase(20, 87);

    // Culls before any setup report not ready
    cull(fct_pkg::MODE_POINT, MIN_Q, MAX_Q, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    cull(fct_pkg::MODE_SPHERE, 32'h0, 32'h0, 32'h0, MIN_Q, 32'h0, 32'h0, 32'h0);
    cull(fct_pkg::MODE_BOX, MAX_Q, MIN_Q, MAX_Q, 32'h0, MIN_Q, MAX_Q, MIN_Q);
    issue(MODE_SPARE_A);
    issue(MODE_SPARE_B);
    issue(fct_pkg::MODE_INVAL);
    // Zero matrix: all planes zero, only the slack decides
    issue(fct_pkg::MODE_SETUP);
    cull(fct_pkg::MODE_POINT, MAX_Q, MIN_Q, MAX_Q, 32'h0, 32'h0, 32'h0, 32'h0);
    cull(fct_pkg::MODE_SPHERE, 32'h0, 32'h0, 32'h0, MIN_Q, 32'h0, 32'h0, 32'h0);
    // Identity matrix: unit cube frustum
    for (k = 0; k < fct_pkg::MAT_DIM; k++) load_elem(k, k, ONE_Q);
    issue(fct_pkg::MODE_SETUP);
    cull(fct_pkg::MODE_POINT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    cull(fct_pkg::MODE_POINT, TWO_Q, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    cull(fct_pkg::MODE_POINT, ONE_Q, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    cull(fct_pkg::MODE_SPHERE, TWO_Q, 32'h0, 32'h0, ONE_Q, 32'h0, 32'h0, 32'h0);
    cull(fct_pkg::MODE_BOX, TWO_Q, 32'h0, 32'h0, 32'h0, NEG_HALF_Q, NEG_HALF_Q,
         NEG_HALF_Q);
    // Loads after setup leave the planes alone until the next setup
    load_elem(3, 3, MIN_Q);
    load_elem(0, 3, MAX_Q);
    cull(fct_pkg::MODE_POINT, TWO_Q, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(fct_pkg::MODE_SETUP);
    cull(fct_pkg::MODE_BOX, MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    issue(fct_pkg::MODE_INVAL);
    cull(fct_pkg::MODE_SPHERE, 32'h0, 32'h0, 32'h0, ONE_Q, 32'h0, 32'h0, 32'h0);

    // Random frames: load a matrix, set up, then a burst of culls
    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      if (phase == 0 && items >= RANDOM_ITEMS/3) begin
        enter_phase(87, 20);
        phase = 1;
      end else if (phase == 1 && items >= 2*RANDOM_ITEMS/3) begin
        enter_phase(0, 0);
        phase = 2;
      end
      style   = $urandom_range(9);
      partial = ($urandom_range(4) == 0);
      for (e = 0; e < 16; e++) begin
        if (!partial || $urandom_range(2) == 0) begin
          if (style < 4) begin
            value = $urandom_range(0, 32'h8000) - 32'h4000;
            if ((e >> 2) == (e & 3)) value = ONE_Q + value + value;
          end else if (style < 8) begin
            value = pick_q(MATRIX_SPAN);
          end else begin
            value = $urandom_range(1) ? $urandom : pick_q(MATRIX_SPAN);
          end
          load_elem(e >> 2, e & 3, value);
          items++;
        end
      end
      if ($urandom_range(9) != 0) begin
        issue(fct_pkg::MODE_SETUP);
        items++;
      end
      n = $urandom_range(4, 30);
      for (k = 0; k < n; k++) begin
        sel = $urandom_range(99);
        if (sel < 4) begin
          issue(fct_pkg::MODE_INVAL);
          items++;
        end else if (sel < 7) begin
          issue($urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B);
        end else if (sel < 12) begin
          load_elem($urandom_range(3), $urandom_range(3), pick_q(MATRIX_SPAN));
          items++;
        end else if (sel < 14) begin
          issue(fct_pkg::MODE_SETUP);
          items++;
        end else begin
          cull_random();
          items++;
        end
      end
    end

    // Drain, let the pipeline settle, then report
    enter_phase(0, 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.verdict_errors == 0 && sb.expected_verdicts.size() == 0) begin
      $display("frustum_cull_tester regression: pass");
    end else begin
      $display("frustum_cull_tester regression: fail");
    end
    $finish;
  end
endmodule
